/* sv/assert_macros.svh */
// assertion macros for the composition rejection sampler
// expects signals named clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRS_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define CRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRS_ASSERT(label, expr)
`define CRS_ASSERT_IMP(label, ante, cons)
`define CRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/crs_pkg.sv */
// shared types, constants and helpers for the composition rejection sampler
// no dependencies
`default_nettype none
package crs_pkg;
  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_GROUPS   = 32;
  localparam int GROUP_SLOTS  = MAX_GROUPS + 1;
  localparam int LIST_DEPTH   = GROUP_SLOTS * MAX_ELEMENTS;

  localparam logic [5:0] ZERO_GROUP = 6'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_ALTER  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_LOG_MODE      = 3'd0,
    REG_LOW_BOUND     = 3'd1,
    REG_HIGH_BOUND    = 3'd2,
    REG_GROUP_TOTAL   = 3'd3,
    REG_BIN_WIDTH     = 3'd4,
    REG_INV_BIN_SCALE = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLS1, S_CLS2, S_CLS3, S_RM_RD, S_RM_LST, S_RM_WR, S_GRD, S_GWR,
    S_THR, S_SCAN, S_IDX, S_LRD, S_LDAT, S_WDAT, S_DONE
  } state_t;

  typedef struct packed {
    logic        log_mode;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic [5:0]  group_total;
    logic [31:0] bin_width;
    logic [47:0] inv_bin_scale;
  } cfg_t;

  typedef struct packed {
    logic [10:0] count;
    logic [47:0] sum;
  } grp_t;

  function automatic logic [4:0] last_group(input logic [5:0] total);
    logic [4:0] r;
    if (total == 6'd0) r = 5'd0;
    else if (total > 6'(MAX_GROUPS)) r = 5'(MAX_GROUPS - 1);
    else r = 5'(total - 6'd1);
    return r;
  endfunction
endpackage
`default_nettype wire

/* sv/crs_classify.sv */
// weight to group mapping, log bins by shifted compares or linear bins through
// a two-stage reciprocal multiply; depends on crs_pkg
`default_nettype none
module crs_classify (
  input  logic          clk,
  input  logic [31:0]   weight,
  input  crs_pkg::cfg_t cfg,
  output logic [5:0]    group
);
  logic [31:0] diff;
  logic [31:0] diff_r;
  logic [63:0] p_lo_r;
  logic [48:0] q_r;
  logic [31:0] below;
  logic [5:0]  below_cnt;
  logic [4:0]  last;
  logic [5:0]  log_group;
  logic [5:0]  lin_group;

  assign diff = weight - cfg.low_bound;

  always_ff @(posedge clk) begin
    diff_r <= diff;
    p_lo_r <= 64'(diff) * 64'(cfg.inv_bin_scale[31:0]);
    q_r    <= 49'(48'(diff_r) * 48'(cfg.inv_bin_scale[47:32])) + 49'(p_lo_r[63:32]);
  end

  // w << (k+1) grows with k, so the set bits form a prefix
  always_comb begin
    for (int k = 0; k < 32; k++) begin
      below[k] = ((64'(weight) << (k + 1)) < 64'(cfg.high_bound));
    end
  end

  assign below_cnt = 6'($countones(below));
  assign last      = crs_pkg::last_group(cfg.group_total);
  assign log_group = (below_cnt > {1'b0, last}) ? {1'b0, last} : below_cnt;

  always_comb begin
    if (weight < cfg.low_bound) begin
      lin_group = 6'd0;
    end else if (q_r > 49'(last)) begin
      lin_group = {1'b0, last};
    end else begin
      lin_group = {1'b0, q_r[4:0]};
    end
  end

  assign group = (weight == 32'd0) ? crs_pkg::ZERO_GROUP :
                 (cfg.log_mode ? log_group : lin_group);
endmodule
`default_nettype wire

/* sv/composition_rejection_sampler.sv */
// composition rejection sampler top level: command sequencer around the element,
// member list and group memories; depends on crs_pkg, crs_classify, assert_macros.svh
//
// usage:
//   input channel (in_valid/in_ready) takes one command per transfer: clear,
//   append, alter or sample attempt with its weight and three random fractions.
//   output channel (out_valid/out_ready) gives one result per command.
//   cfg_we/cfg_index/cfg_data write the six setup registers while idle.
// sequencing, one command at a time: clear goes straight to done; a valid
//   append or alter classifies, reads and writes the group, alter first unlinking
//   the element when it changes group; a sample attempt scans the group sums,
//   one read of the group memory per cycle, and tests a member of a non-empty group.
// reset: counts and sums read as zero through per-group valid bits, so no
//   clearing pass; element and member memories stay undefined until written.
// stall: a finished result waits in the output register while the next
//   command is already taken; the sequencer holds only if a second result
//   is ready before the first transfer.
`default_nettype none
`include "assert_macros.svh"
module composition_rejection_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_element,
  input  logic [31:0] in_weight,
  input  logic [15:0] in_rand_group,
  input  logic [15:0] in_rand_member,
  input  logic [15:0] in_rand_accept,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_chosen,
  output logic        out_accepted,
  output logic [5:0]  out_group_index,
  output logic [1:0]  out_status,
  output logic [47:0] out_total_weight,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  crs_pkg::state_t  state_r, state_nxt;
  crs_pkg::cfg_t    cfg_r;
  crs_pkg::cmd_t    cmd_r;
  crs_pkg::status_t res_status_r;

  logic [9:0]  e_r;
  logic [31:0] w_r;
  logic [15:0] rg_r, rm_r, ra_r;
  logic [31:0] old_r;
  logic [5:0]  og_r, ng_r;
  logic [9:0]  slot_r;
  logic        same_r;
  logic [10:0] cnt_r;
  logic [47:0] sum_r;
  logic [47:0] grand_r;
  logic [10:0] etot_r;
  logic [47:0] thr_r;
  logic [53:0] partial_r;
  logic [4:0]  scan_r, chk_r;
  logic        chk_v_r;
  logic [9:0]  idx_r;
  logic [37:0] bmul_r;
  logic [38:0] bound_r;
  logic [54:0] bprod_r;
  logic [9:0]  res_chosen_r;
  logic        res_acc_r;
  logic [5:0]  res_gidx_r;
  logic        out_valid_r;
  logic [9:0]  out_chosen_r;
  logic        out_acc_r;
  logic [5:0]  out_gidx_r;
  logic [1:0]  out_status_r;
  logic [47:0] out_total_r;

  // memories
  logic [31:0] wmem [0:crs_pkg::MAX_ELEMENTS-1];
  logic [5:0]  gmem [0:crs_pkg::MAX_ELEMENTS-1];
  logic [9:0]  smem [0:crs_pkg::MAX_ELEMENTS-1];
  logic [9:0]  lmem [0:crs_pkg::LIST_DEPTH-1];
  crs_pkg::grp_t grp_mem [0:crs_pkg::GROUP_SLOTS-1];
  logic [crs_pkg::GROUP_SLOTS-1:0] grp_vld_r;

  logic [31:0] wm_q_r;
  logic [5:0]  gm_q_r;
  logic [9:0]  sm_q_r;
  logic [9:0]  lm_q_r;
  crs_pkg::grp_t gr_q_r;
  logic        gr_qv_r;

  logic [9:0]  wm_ra;
  logic        wm_we, gm_we;
  logic        sm_we;
  logic [9:0]  sm_wa, sm_wd;
  logic [15:0] lm_ra, lm_wa;
  logic        lm_we;
  logic [9:0]  lm_wd;
  logic [5:0]  gr_ra, gr_wa;
  logic        gr_we;
  crs_pkg::grp_t gr_wd;

  crs_pkg::grp_t gd;
  logic [5:0]  cls_group;
  logic [4:0]  last;
  logic [53:0] psum;
  logic        hit;
  logic        take;
  logic        full;
  logic        alt_bad;
  logic        out_load;

  crs_classify u_classify (
    .clk    (clk),
    .weight (w_r),
    .cfg    (cfg_r),
    .group  (cls_group)
  );

  assign in_ready = (state_r == crs_pkg::S_IDLE);
  assign take     = in_valid && in_ready;
  assign full     = etot_r >= 11'(crs_pkg::MAX_ELEMENTS);
  assign alt_bad  = {1'b0, in_element} >= etot_r;
  assign last     = crs_pkg::last_group(cfg_r.group_total);
  assign gd       = gr_qv_r ? gr_q_r : '0;
  assign psum     = partial_r + 54'(gd.sum);
  assign hit      = (state_r == crs_pkg::S_SCAN) && chk_v_r &&
                    ((psum > 54'(thr_r)) || (chk_r == last));
  assign out_load = (state_r == crs_pkg::S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            crs_pkg::CMD_CLEAR:  state_nxt = crs_pkg::S_DONE;
            crs_pkg::CMD_APPEND: state_nxt = full ? crs_pkg::S_DONE : crs_pkg::S_CLS1;
            crs_pkg::CMD_ALTER:  state_nxt = alt_bad ? crs_pkg::S_DONE : crs_pkg::S_CLS1;
            default:             state_nxt = crs_pkg::S_THR;
          endcase
        end
      end
      crs_pkg::S_CLS1: state_nxt = crs_pkg::S_CLS2;
      crs_pkg::S_CLS2: state_nxt = crs_pkg::S_CLS3;
      crs_pkg::S_CLS3: begin
        if (cmd_r == crs_pkg::CMD_ALTER && og_r != cls_group) state_nxt = crs_pkg::S_RM_RD;
        else state_nxt = crs_pkg::S_GRD;
      end
      crs_pkg::S_RM_RD:  state_nxt = crs_pkg::S_RM_LST;
      crs_pkg::S_RM_LST: state_nxt = crs_pkg::S_RM_WR;
      crs_pkg::S_RM_WR:  state_nxt = crs_pkg::S_GRD;
      crs_pkg::S_GRD:    state_nxt = crs_pkg::S_GWR;
      crs_pkg::S_GWR:    state_nxt = crs_pkg::S_DONE;
      crs_pkg::S_THR:    state_nxt = crs_pkg::S_SCAN;
      crs_pkg::S_SCAN:   if (hit) state_nxt = crs_pkg::S_IDX;
      crs_pkg::S_IDX:    state_nxt = (cnt_r == 11'd0) ? crs_pkg::S_DONE : crs_pkg::S_LRD;
      crs_pkg::S_LRD:    state_nxt = crs_pkg::S_LDAT;
      crs_pkg::S_LDAT:   state_nxt = crs_pkg::S_WDAT;
      crs_pkg::S_WDAT:   state_nxt = crs_pkg::S_DONE;
      crs_pkg::S_DONE:   if (out_load) state_nxt = crs_pkg::S_IDLE;
      default:           state_nxt = crs_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    wm_ra = e_r;
    wm_we = 1'b0;
    gm_we = 1'b0;
    sm_we = 1'b0;
    sm_wa = e_r;
    sm_wd = gd.count[9:0];
    lm_ra = {ng_r, idx_r};
    lm_we = 1'b0;
    lm_wa = {ng_r, gd.count[9:0]};
    lm_wd = e_r;
    gr_ra = {1'b0, scan_r};
    gr_we = 1'b0;
    gr_wa = ng_r;
    gr_wd = '{count: gd.count + 11'd1, sum: gd.sum + 48'(w_r)};
    case (state_r)
      crs_pkg::S_RM_RD: gr_ra = og_r;
      crs_pkg::S_RM_LST: lm_ra = {og_r, 10'(gd.count - 11'd1)};
      crs_pkg::S_RM_WR: begin
        gr_we = 1'b1;
        gr_wa = og_r;
        gr_wd = '{count: (cnt_r == 11'd0) ? cnt_r : cnt_r - 11'd1,
                  sum: sum_r - 48'(old_r)};
        lm_we = (cnt_r != 11'd0);
        lm_wa = {og_r, slot_r};
        lm_wd = lm_q_r;
        sm_we = (cnt_r != 11'd0);
        sm_wa = lm_q_r;
        sm_wd = slot_r;
      end
      crs_pkg::S_GRD: gr_ra = ng_r;
      crs_pkg::S_GWR: begin
        wm_we = 1'b1;
        gr_we = 1'b1;
        if (same_r) begin
          gr_wd = '{count: gd.count, sum: gd.sum + 48'(w_r) - 48'(old_r)};
        end else begin
          gm_we = 1'b1;
          sm_we = 1'b1;
          lm_we = 1'b1;
        end
      end
      crs_pkg::S_LDAT: wm_ra = lm_q_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wm_we) wmem[e_r] <= w_r;
    if (gm_we) gmem[e_r] <= ng_r;
    if (sm_we) smem[sm_wa] <= sm_wd;
    if (lm_we) lmem[lm_wa] <= lm_wd;
    if (gr_we) grp_mem[gr_wa] <= gr_wd;
    wm_q_r  <= wmem[wm_ra];
    gm_q_r  <= gmem[e_r];
    sm_q_r  <= smem[e_r];
    lm_q_r  <= lmem[lm_ra];
    gr_q_r  <= grp_mem[gr_ra];
    gr_qv_r <= grp_vld_r[gr_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crs_pkg::S_IDLE;
      cfg_r       <= '{log_mode: 1'b0, low_bound: 32'd0, high_bound: 32'hFFFF_FFFF,
                       group_total: 6'd32, bin_width: 32'd134217728,
                       inv_bin_scale: 48'd32};
      grand_r     <= '0;
      etot_r      <= '0;
      grp_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          crs_pkg::REG_LOG_MODE:      cfg_r.log_mode      <= cfg_data[0];
          crs_pkg::REG_LOW_BOUND:     cfg_r.low_bound     <= cfg_data[31:0];
          crs_pkg::REG_HIGH_BOUND:    cfg_r.high_bound    <= cfg_data[31:0];
          crs_pkg::REG_GROUP_TOTAL:   cfg_r.group_total   <= cfg_data[5:0];
          crs_pkg::REG_BIN_WIDTH:     cfg_r.bin_width     <= cfg_data[31:0];
          crs_pkg::REG_INV_BIN_SCALE: cfg_r.inv_bin_scale <= cfg_data;
          default: ;
        endcase
      end
      if (take && in_cmd == crs_pkg::CMD_CLEAR) begin
        grand_r   <= '0;
        etot_r    <= '0;
        grp_vld_r <= '0;
      end
      if (gr_we) grp_vld_r[gr_wa] <= 1'b1;
      if (state_r == crs_pkg::S_GWR) begin
        grand_r <= grand_r + 48'(w_r) - 48'(old_r);
        if (cmd_r == crs_pkg::CMD_APPEND) etot_r <= etot_r + 11'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      crs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_r        <= crs_pkg::cmd_t'(in_cmd);
          e_r          <= (in_cmd == crs_pkg::CMD_APPEND) ? etot_r[9:0] : in_element;
          w_r          <= in_weight;
          rg_r         <= in_rand_group;
          rm_r         <= in_rand_member;
          ra_r         <= in_rand_accept;
          old_r        <= '0;
          same_r       <= 1'b0;
          res_acc_r    <= 1'b0;
          res_gidx_r   <= '0;
          if (in_cmd == crs_pkg::CMD_ALTER) begin
            res_chosen_r <= in_element;
          end else if (in_cmd == crs_pkg::CMD_APPEND && !full) begin
            res_chosen_r <= etot_r[9:0];
          end else begin
            res_chosen_r <= '0;
          end
          if ((in_cmd == crs_pkg::CMD_ALTER && alt_bad) ||
              (in_cmd == crs_pkg::CMD_APPEND && full)) begin
            res_status_r <= crs_pkg::STAT_BAD;
          end else begin
            res_status_r <= crs_pkg::STAT_OK;
          end
        end
      end
      crs_pkg::S_CLS2: begin
        if (cmd_r == crs_pkg::CMD_ALTER) begin
          old_r  <= wm_q_r;
          og_r   <= gm_q_r;
          slot_r <= sm_q_r;
        end
      end
      crs_pkg::S_CLS3: begin
        ng_r       <= cls_group;
        res_gidx_r <= cls_group;
        same_r     <= (cmd_r == crs_pkg::CMD_ALTER) && (og_r == cls_group);
      end
      crs_pkg::S_RM_LST: begin
        cnt_r <= gd.count;
        sum_r <= gd.sum;
      end
      crs_pkg::S_THR: begin
        thr_r     <= 48'((64'(grand_r) * 64'(rg_r)) >> 16);
        scan_r    <= '0;
        chk_v_r   <= 1'b0;
        partial_r <= '0;
      end
      crs_pkg::S_SCAN: begin
        chk_r   <= scan_r;
        chk_v_r <= 1'b1;
        if (scan_r != last) scan_r <= scan_r + 5'd1;
        if (chk_v_r) partial_r <= psum;
        if (hit) begin
          ng_r       <= {1'b0, chk_r};
          res_gidx_r <= {1'b0, chk_r};
          cnt_r      <= gd.count;
        end
      end
      crs_pkg::S_IDX: begin
        if (cnt_r == 11'd0) res_status_r <= crs_pkg::STAT_EMPTY;
        idx_r  <= 10'((27'(cnt_r) * 27'(rm_r)) >> 16);
        bmul_r <= (38'(ng_r) + 38'd1) * 38'(cfg_r.bin_width);
      end
      crs_pkg::S_LRD: begin
        if (cfg_r.log_mode) bound_r <= 39'(cfg_r.high_bound >> ng_r);
        else if (ng_r >= {1'b0, last}) bound_r <= 39'(cfg_r.high_bound);
        else bound_r <= 39'(cfg_r.low_bound) + 39'(bmul_r);
      end
      crs_pkg::S_LDAT: begin
        res_chosen_r <= lm_q_r;
        bprod_r      <= 55'(bound_r) * 55'(ra_r);
      end
      crs_pkg::S_WDAT: begin
        res_acc_r <= 55'({wm_q_r, 16'h0000}) > bprod_r;
      end
      crs_pkg::S_DONE: begin
        if (out_load) begin
          out_chosen_r <= res_chosen_r;
          out_acc_r    <= res_acc_r;
          out_gidx_r   <= res_gidx_r;
          out_status_r <= res_status_r;
          out_total_r  <= grand_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_chosen       = out_chosen_r;
  assign out_accepted     = out_acc_r;
  assign out_group_index  = out_gidx_r;
  assign out_status       = out_status_r;
  assign out_total_weight = out_total_r;

  `CRS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CRS_ASSERT(a_elem_bound, etot_r <= 11'(crs_pkg::MAX_ELEMENTS))
  `CRS_ASSERT_IMP(a_empty_no_pick, out_valid && out_status == crs_pkg::STAT_EMPTY, out_chosen == 10'd0 && !out_accepted)
endmodule
`default_nettype wire
